@@ src/taab_pkg.sv @@
// ---------------------------------------------------------------------------
// taab_pkg: shared constants and types for the transformed box bounds block
// Fixed coefficient format, matrix row layout and corner count.
// ---------------------------------------------------------------------------
`default_nettype none

package taab_pkg;

    // coefficient format: signed Q4.12, four per row word
    localparam int COEF_WIDTH  = 16;
    localparam int COEF_FRAC   = 12;
    localparam int NUM_COLS    = 4;
    localparam int ROW_WIDTH   = COEF_WIDTH * NUM_COLS;

    // coordinate fraction bits (Q8.8), so 1.0 is one shifted by this
    localparam int COORD_FRAC  = 8;

    // geometry
    localparam int NUM_AXES    = 3;
    localparam int NUM_CORNERS = 8;

    // translation term width: coefficient times 1.0
    localparam int TRANS_WIDTH = COEF_WIDTH + COORD_FRAC;

    typedef logic [ROW_WIDTH-1:0]          t_row;
    typedef logic signed [COEF_WIDTH-1:0]  t_coef;
    typedef logic signed [TRANS_WIDTH-1:0] t_trans;

endpackage

`default_nettype wire

@@ src/taab_in_if.sv @@
// ---------------------------------------------------------------------------
// taab_in_if: input channel of the transformed box bounds block
// Carries the local box corners and the three affine matrix rows.
// ---------------------------------------------------------------------------
`default_nettype none

interface taab_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] local_min_x;
    logic signed [COORD_WIDTH-1:0] local_min_y;
    logic signed [COORD_WIDTH-1:0] local_min_z;
    logic signed [COORD_WIDTH-1:0] local_max_x;
    logic signed [COORD_WIDTH-1:0] local_max_y;
    logic signed [COORD_WIDTH-1:0] local_max_z;
    taab_pkg::t_row                matrix_row_x;
    taab_pkg::t_row                matrix_row_y;
    taab_pkg::t_row                matrix_row_z;

    modport source (
        output valid, local_min_x, local_min_y, local_min_z,
               local_max_x, local_max_y, local_max_z,
               matrix_row_x, matrix_row_y, matrix_row_z,
        input  ready
    );

    modport sink (
        input  valid, local_min_x, local_min_y, local_min_z,
               local_max_x, local_max_y, local_max_z,
               matrix_row_x, matrix_row_y, matrix_row_z,
        output ready
    );
endinterface

`default_nettype wire

@@ src/taab_out_if.sv @@
// ---------------------------------------------------------------------------
// taab_out_if: result channel of the transformed box bounds block
// Carries the world box and the two transformed local corners.
// ---------------------------------------------------------------------------
`default_nettype none

interface taab_out_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] aabb_min_x;
    logic signed [COORD_WIDTH-1:0] aabb_min_y;
    logic signed [COORD_WIDTH-1:0] aabb_min_z;
    logic signed [COORD_WIDTH-1:0] aabb_max_x;
    logic signed [COORD_WIDTH-1:0] aabb_max_y;
    logic signed [COORD_WIDTH-1:0] aabb_max_z;
    logic signed [COORD_WIDTH-1:0] moved_min_x;
    logic signed [COORD_WIDTH-1:0] moved_min_y;
    logic signed [COORD_WIDTH-1:0] moved_min_z;
    logic signed [COORD_WIDTH-1:0] moved_max_x;
    logic signed [COORD_WIDTH-1:0] moved_max_y;
    logic signed [COORD_WIDTH-1:0] moved_max_z;

    modport source (
        output valid, aabb_min_x, aabb_min_y, aabb_min_z,
               aabb_max_x, aabb_max_y, aabb_max_z,
               moved_min_x, moved_min_y, moved_min_z,
               moved_max_x, moved_max_y, moved_max_z,
        input  ready
    );

    modport sink (
        input  valid, aabb_min_x, aabb_min_y, aabb_min_z,
               aabb_max_x, aabb_max_y, aabb_max_z,
               moved_min_x, moved_min_y, moved_min_z,
               moved_max_x, moved_max_y, moved_max_z,
        output ready
    );
endinterface

`default_nettype wire

@@ src/taab_mul.sv @@
// ---------------------------------------------------------------------------
// taab_mul: product stage
// Forms every coefficient-by-coordinate product once for the minimum and
// the maximum coordinate of each axis, plus the translation terms.
// ---------------------------------------------------------------------------
`default_nettype none

module taab_mul #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_en,
    input  wire logic signed [COORD_WIDTH-1:0]              i_lo    [taab_pkg::NUM_AXES],
    input  wire logic signed [COORD_WIDTH-1:0]              i_hi    [taab_pkg::NUM_AXES],
    input  wire taab_pkg::t_row                             i_row   [taab_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH+taab_pkg::COEF_WIDTH-1:0]
                                                            o_prod_lo
                                                            [taab_pkg::NUM_AXES]
                                                            [taab_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH+taab_pkg::COEF_WIDTH-1:0]
                                                            o_prod_hi
                                                            [taab_pkg::NUM_AXES]
                                                            [taab_pkg::NUM_AXES],
    output taab_pkg::t_trans                                o_trans [taab_pkg::NUM_AXES]
);
    localparam int PW = COORD_WIDTH + taab_pkg::COEF_WIDTH;
    localparam int NA = taab_pkg::NUM_AXES;
    localparam int CW = taab_pkg::COEF_WIDTH;

    logic signed [PW-1:0] n_prod_lo [NA][NA];
    logic signed [PW-1:0] n_prod_hi [NA][NA];
    taab_pkg::t_trans     n_trans   [NA];
    taab_pkg::t_coef      coef      [NA][NA];
    taab_pkg::t_coef      coef_t    [NA];

    // one multiplier per row, column and corner choice
    always_comb begin
        for (int r = 0; r < NA; r++) begin
            for (int a = 0; a < NA; a++) begin
                coef[r][a]      = taab_pkg::t_coef'(i_row[r][CW*a +: CW]);
                n_prod_lo[r][a] = PW'(coef[r][a]) * PW'(i_lo[a]);
                n_prod_hi[r][a] = PW'(coef[r][a]) * PW'(i_hi[a]);
            end
            coef_t[r]  = taab_pkg::t_coef'(i_row[r][CW*NA +: CW]);
            // translation column times 1.0
            n_trans[r] = {coef_t[r], {taab_pkg::COORD_FRAC{1'b0}}};
        end
    end

    // product registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_prod_lo <= n_prod_lo;
            o_prod_hi <= n_prod_hi;
            o_trans   <= n_trans;
        end
    end

endmodule

`default_nettype wire

@@ src/taab_lane.sv @@
// ---------------------------------------------------------------------------
// taab_lane: one corner lane
// Sums the products of one corner for all three rows, rounds to Q8.8 with
// halves going up and saturates to the coordinate range.
// ---------------------------------------------------------------------------
`default_nettype none

module taab_lane #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_en,
    input  wire logic signed [COORD_WIDTH+taab_pkg::COEF_WIDTH-1:0]
                                                            i_prod
                                                            [taab_pkg::NUM_AXES]
                                                            [taab_pkg::NUM_AXES],
    input  wire taab_pkg::t_trans                           i_trans [taab_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0]                   o_val   [taab_pkg::NUM_AXES]
);
    localparam int NA = taab_pkg::NUM_AXES;
    localparam int AW = COORD_WIDTH + taab_pkg::COEF_WIDTH + 2;
    localparam int FR = taab_pkg::COEF_FRAC;
    localparam int SW = AW - FR;

    logic signed [AW-1:0]          acc   [NA];
    logic signed [SW-1:0]          rnd   [NA];
    logic                          ovf_hi[NA];
    logic                          ovf_lo[NA];
    logic signed [COORD_WIDTH-1:0] n_val [NA];

    // accumulate, round, saturate
    always_comb begin
        for (int r = 0; r < NA; r++) begin
            acc[r] = AW'(i_prod[r][0]) + AW'(i_prod[r][1]) + AW'(i_prod[r][2])
                   + AW'(i_trans[r]) + (AW'(1) <<< (FR - 1));
            rnd[r] = acc[r][AW-1:FR];
            ovf_hi[r] = !rnd[r][SW-1] && (|rnd[r][SW-2:COORD_WIDTH-1]);
            ovf_lo[r] = rnd[r][SW-1] && !(&rnd[r][SW-2:COORD_WIDTH-1]);
            priority if (ovf_hi[r]) begin
                n_val[r] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end else if (ovf_lo[r]) begin
                n_val[r] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            end else begin
                n_val[r] = rnd[r][COORD_WIDTH-1:0];
            end
        end
    end

    // corner result registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_val <= n_val;
        end
    end

endmodule

`default_nettype wire

@@ src/taab_merge.sv @@
// ---------------------------------------------------------------------------
// taab_merge: merge stage
// Takes the component-wise minimum and maximum over the eight lanes and
// picks out the transformed minimum and maximum corners.
// ---------------------------------------------------------------------------
`default_nettype none

module taab_merge #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [COORD_WIDTH-1:0]
                                             i_val [taab_pkg::NUM_CORNERS]
                                                   [taab_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0]    o_aabb_min  [taab_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0]    o_aabb_max  [taab_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0]    o_moved_min [taab_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0]    o_moved_max [taab_pkg::NUM_AXES]
);
    localparam int NA = taab_pkg::NUM_AXES;
    localparam int NC = taab_pkg::NUM_CORNERS;

    logic signed [COORD_WIDTH-1:0] n_min [NA];
    logic signed [COORD_WIDTH-1:0] n_max [NA];

    // running minimum and maximum across the lanes
    always_comb begin
        for (int r = 0; r < NA; r++) begin
            n_min[r] = i_val[0][r];
            n_max[r] = i_val[0][r];
            for (int c = 1; c < NC; c++) begin
                if (i_val[c][r] < n_min[r]) begin
                    n_min[r] = i_val[c][r];
                end
                if (i_val[c][r] > n_max[r]) begin
                    n_max[r] = i_val[c][r];
                end
            end
        end
    end

    // output registers; all-low corner is the moved minimum, all-high the maximum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_aabb_min  <= n_min;
            o_aabb_max  <= n_max;
            o_moved_min <= i_val[0];
            o_moved_max <= i_val[NC-1];
        end
    end

endmodule

`default_nettype wire

@@ src/transformed_aabb_bounds.sv @@
// ---------------------------------------------------------------------------
// transformed_aabb_bounds: world bounds of an affinely transformed box
// Transforms the eight corners of a local box by a 3x4 Q4.12 matrix and
// returns the component-wise bounds and the two moved corners.
// ---------------------------------------------------------------------------
// Usage:
//   i_box carries one transaction per box: the local minimum and maximum
//   corners (signed Q8.8) and three matrix rows of four Q4.12 coefficients.
//   o_box carries the world box, rounded to nearest (halves up) and
//   saturated, plus the transformed local minimum and maximum corners.
//   Both channels move a transaction when valid and ready are high together.
// Throughput: one transaction per cycle while o_box.ready is high. Eight corner lanes work in
//   parallel, each with three row sums, behind a shared product stage.
// Pipeline: from input to output valid a transaction passes the product register,
//   lane sum/round/saturate register, merge (min/max) output register.
// Reset: clears the stage valid flags only; no transaction is in flight.
// Stall: when o_box.ready is low the output holds; earlier stages keep
//   filling any empty slot, so i_box.ready falls only once all three stages
//   hold a transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module transformed_aabb_bounds #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    taab_in_if.sink       i_box,
    taab_out_if.source    o_box
);
    localparam int NA = taab_pkg::NUM_AXES;
    localparam int NC = taab_pkg::NUM_CORNERS;
    localparam int PW = COORD_WIDTH + taab_pkg::COEF_WIDTH;

    logic r_valid_a;
    logic r_valid_b;
    logic r_valid_c;
    logic en_a;
    logic en_b;
    logic en_c;

    logic signed [COORD_WIDTH-1:0] box_lo [NA];
    logic signed [COORD_WIDTH-1:0] box_hi [NA];
    taab_pkg::t_row                rows   [NA];

    logic signed [PW-1:0]          prod_lo [NA][NA];
    logic signed [PW-1:0]          prod_hi [NA][NA];
    taab_pkg::t_trans              trans   [NA];
    logic signed [COORD_WIDTH-1:0] corner  [NC][NA];

    logic signed [COORD_WIDTH-1:0] aabb_min  [NA];
    logic signed [COORD_WIDTH-1:0] aabb_max  [NA];
    logic signed [COORD_WIDTH-1:0] moved_min [NA];
    logic signed [COORD_WIDTH-1:0] moved_max [NA];

    // stage enables: a stage moves when it is empty or its successor moves
    assign en_c        = !r_valid_c || o_box.ready;
    assign en_b        = !r_valid_b || en_c;
    assign en_a        = !r_valid_a || en_b;
    assign i_box.ready = en_a;
    assign o_box.valid = r_valid_c;

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
            r_valid_c <= 1'b0;
        end else begin
            if (en_a) begin
                r_valid_a <= i_box.valid;
            end
            if (en_b) begin
                r_valid_b <= r_valid_a;
            end
            if (en_c) begin
                r_valid_c <= r_valid_b;
            end
        end
    end

    // input payload to arrays
    assign box_lo[0] = i_box.local_min_x;
    assign box_lo[1] = i_box.local_min_y;
    assign box_lo[2] = i_box.local_min_z;
    assign box_hi[0] = i_box.local_max_x;
    assign box_hi[1] = i_box.local_max_y;
    assign box_hi[2] = i_box.local_max_z;
    assign rows[0]   = i_box.matrix_row_x;
    assign rows[1]   = i_box.matrix_row_y;
    assign rows[2]   = i_box.matrix_row_z;

    // shared product stage
    taab_mul #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mul (
        .i_clk     (i_clk),
        .i_en      (en_a),
        .i_lo      (box_lo),
        .i_hi      (box_hi),
        .i_row     (rows),
        .o_prod_lo (prod_lo),
        .o_prod_hi (prod_hi),
        .o_trans   (trans)
    );

    // corner lanes: bit a of the corner index picks the maximum on axis a
    for (genvar c = 0; c < NC; c++) begin : g_lane
        localparam logic [NA-1:0] SEL = NA'(c);
        logic signed [PW-1:0] lane_prod [NA][NA];

        always_comb begin
            for (int r = 0; r < NA; r++) begin
                for (int a = 0; a < NA; a++) begin
                    lane_prod[r][a] = SEL[a] ? prod_hi[r][a] : prod_lo[r][a];
                end
            end
        end

        taab_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (en_b),
            .i_prod  (lane_prod),
            .i_trans (trans),
            .o_val   (corner[c])
        );
    end

    // merge stage and output register
    taab_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .i_clk       (i_clk),
        .i_en        (en_c),
        .i_val       (corner),
        .o_aabb_min  (aabb_min),
        .o_aabb_max  (aabb_max),
        .o_moved_min (moved_min),
        .o_moved_max (moved_max)
    );

    // result payload
    assign o_box.aabb_min_x  = aabb_min[0];
    assign o_box.aabb_min_y  = aabb_min[1];
    assign o_box.aabb_min_z  = aabb_min[2];
    assign o_box.aabb_max_x  = aabb_max[0];
    assign o_box.aabb_max_y  = aabb_max[1];
    assign o_box.aabb_max_z  = aabb_max[2];
    assign o_box.moved_min_x = moved_min[0];
    assign o_box.moved_min_y = moved_min[1];
    assign o_box.moved_min_z = moved_min[2];
    assign o_box.moved_max_x = moved_max[0];
    assign o_box.moved_max_y = moved_max[1];
    assign o_box.moved_max_z = moved_max[2];

endmodule

`default_nettype wire

@@ src/taab_check.sv @@
// ---------------------------------------------------------------------------
// taab_check: port checker for the transformed box bounds block
// Watches the result channel for reset behaviour, stall holding and the
// ordering of the reported bounds.
// ---------------------------------------------------------------------------
`default_nettype none

module taab_check #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_amin_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_amin_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_amin_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_amax_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_amax_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_amax_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_mmin_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_mmax_x
);

    // no transaction offered straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // a stalled result stays offered and its x bounds stay unchanged
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_amin_x) && $stable(i_amax_x))
        else $error("stalled result dropped or changed");

    // world box is never inverted
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_amin_x <= i_amax_x) && (i_amin_y <= i_amax_y)
                        && (i_amin_z <= i_amax_z))
        else $error("world box minimum above maximum");

    // moved corners lie inside the world box on the x axis
    a_moved_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_mmin_x >= i_amin_x) && (i_mmin_x <= i_amax_x)
                        && (i_mmax_x >= i_amin_x) && (i_mmax_x <= i_amax_x))
        else $error("moved corner outside world box");

endmodule

bind transformed_aabb_bounds taab_check #(
    .COORD_WIDTH (COORD_WIDTH)
) u_taab_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_box.valid),
    .i_out_ready (o_box.ready),
    .i_amin_x    (o_box.aabb_min_x),
    .i_amin_y    (o_box.aabb_min_y),
    .i_amin_z    (o_box.aabb_min_z),
    .i_amax_x    (o_box.aabb_max_x),
    .i_amax_y    (o_box.aabb_max_y),
    .i_amax_z    (o_box.aabb_max_z),
    .i_mmin_x    (o_box.moved_min_x),
    .i_mmax_x    (o_box.moved_max_x)
);

`default_nettype wire

@@ dv/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: testbench for the transformed box bounds block
// Streams local boxes and 3x4 matrices through the block with random gaps
// and output back-pressure. A local predictor transforms all eight corners
// and queues the expected world box and moved corners; each result
// transaction is compared field by field with the oldest expectation.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int W = 16;

    typedef logic signed [W-1:0] t_coord;

    // one input transaction
    typedef struct {
        t_coord         lo  [3];
        t_coord         hi  [3];
        taab_pkg::t_row row [3];
    } t_box;

    // one result transaction in output order:
    // aabb min xyz, aabb max xyz, moved min xyz, moved max xyz
    typedef struct {
        t_coord f [12];
    } t_bounds;

    localparam taab_pkg::t_coef ONE     = 16'sh1000;
    localparam taab_pkg::t_coef NEG_ONE = 16'shF000;
    localparam taab_pkg::t_coef C_MAX   = 16'sh7FFF;
    localparam taab_pkg::t_coef C_MIN   = 16'sh8000;
    localparam t_coord P_MAX  = 16'sh7FFF;
    localparam t_coord P_MIN  = 16'sh8000;

    logic i_clk;
    logic i_rst_n;

    taab_in_if  #(.COORD_WIDTH(W)) box_in ();
    taab_out_if #(.COORD_WIDTH(W)) box_out ();

    transformed_aabb_bounds #(
        .COORD_WIDTH(W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_in),
        .o_box   (box_out)
    );

    t_bounds expected_bounds_q [$];
    int      mismatch_count = 0;
    bit      tx_idle = 1'b1;
    bit      rx_idle = 1'b1;
    int      rx_hold_cycles = 0;
    string   group_names [4] = '{"aabb_min", "aabb_max", "moved_min", "moved_max"};
    string   axis_names [3]  = '{"x", "y", "z"};

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4000000;
        $display("FAIL transformed_aabb_bounds");
        $finish;
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    // one row of the affine transform, rounded half up and saturated
    function automatic t_coord move_coord(input taab_pkg::t_row row, input t_coord x,
                                          input t_coord y, input t_coord z);
        longint acc;
        longint sum;
        longint lim_hi;
        longint lim_lo;
        lim_hi = (longint'(1) <<< (W - 1)) - 1;
        lim_lo = -lim_hi - 1;
        acc = longint'(taab_pkg::t_coef'(row[15:0]))  * longint'(x)
            + longint'(taab_pkg::t_coef'(row[31:16])) * longint'(y)
            + longint'(taab_pkg::t_coef'(row[47:32])) * longint'(z)
            + longint'(taab_pkg::t_coef'(row[63:48]))
              * (longint'(1) <<< taab_pkg::COORD_FRAC);
        sum = (acc + (longint'(1) <<< (taab_pkg::COEF_FRAC - 1))) >>> taab_pkg::COEF_FRAC;
        if (sum > lim_hi) sum = lim_hi;
        if (sum < lim_lo) sum = lim_lo;
        return t_coord'(sum);
    endfunction

    // world box and moved corners over all eight corners
    function automatic t_bounds predict_bounds(input t_box b);
        t_bounds e;
        t_coord  p [3];
        t_coord  v;
        for (int c = 0; c < taab_pkg::NUM_CORNERS; c++) begin
            for (int a = 0; a < 3; a++) begin
                p[a] = ((c >> a) & 1) ? b.hi[a] : b.lo[a];
            end
            for (int r = 0; r < 3; r++) begin
                v = move_coord(b.row[r], p[0], p[1], p[2]);
                if (c == 0) begin
                    e.f[r]     = v;
                    e.f[3 + r] = v;
                    e.f[6 + r] = v;
                end else begin
                    if (v < e.f[r])     e.f[r] = v;
                    if (v > e.f[3 + r]) e.f[3 + r] = v;
                end
                if (c == taab_pkg::NUM_CORNERS - 1) e.f[9 + r] = v;
            end
        end
        return e;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    function automatic taab_pkg::t_row pack_row(input taab_pkg::t_coef c0,
                                                input taab_pkg::t_coef c1,
                                                input taab_pkg::t_coef c2,
                                                input taab_pkg::t_coef c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic t_box make_box(input t_coord lx, input t_coord ly,
                                      input t_coord lz, input t_coord hx,
                                      input t_coord hy, input t_coord hz,
                                      input taab_pkg::t_row rx, input taab_pkg::t_row ry,
                                      input taab_pkg::t_row rz);
        t_box b;
        b.lo  = '{lx, ly, lz};
        b.hi  = '{hx, hy, hz};
        b.row = '{rx, ry, rz};
        return b;
    endfunction

    function automatic taab_pkg::t_coef rand_coef(input int span);
        return taab_pkg::t_coef'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic taab_pkg::t_row rand_row(input int span, input int trans_span);
        return pack_row(rand_coef(span), rand_coef(span), rand_coef(span),
                        rand_coef(trans_span));
    endfunction

    // mostly plausible scene boxes and model matrices, plus raw noise,
    // tiny coefficients for rounding and huge ones for saturation
    function automatic t_box rand_box();
        t_box   b;
        int     kind;
        int     cen;
        int     half;
        t_coord tmp;
        kind = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) begin
            if (kind <= 5 || kind == 9) begin
                cen      = $urandom_range(0, 16000) - 8000;
                half     = $urandom_range(0, 4000);
                b.lo[a]  = t_coord'(cen - half);
                b.hi[a]  = t_coord'(cen + half);
            end else begin
                b.lo[a]  = t_coord'($urandom);
                b.hi[a]  = t_coord'($urandom);
            end
            if (kind <= 5)
                b.row[a] = rand_row(4096, 32767);
            else if (kind <= 7)
                b.row[a] = {$urandom, $urandom};
            else if (kind == 8)
                b.row[a] = rand_row(64, 64);
            else
                b.row[a] = rand_row(32767, 32767);
        end
        // occasionally an inverted axis
        if ($urandom_range(0, 15) == 0) begin
            kind      = $urandom_range(0, 2);
            tmp       = b.lo[kind];
            b.lo[kind] = b.hi[kind];
            b.hi[kind] = tmp;
        end
        return b;
    endfunction

    // ---------------------------------------------------------------------
    // driver, receiver and checker
    // ---------------------------------------------------------------------

    // offer one box and wait for the transaction to be taken
    task automatic send_box(input t_box b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            box_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        box_in.valid        <= 1'b1;
        box_in.local_min_x  <= b.lo[0];
        box_in.local_min_y  <= b.lo[1];
        box_in.local_min_z  <= b.lo[2];
        box_in.local_max_x  <= b.hi[0];
        box_in.local_max_y  <= b.hi[1];
        box_in.local_max_z  <= b.hi[2];
        box_in.matrix_row_x <= b.row[0];
        box_in.matrix_row_y <= b.row[1];
        box_in.matrix_row_z <= b.row[2];
        do @(posedge i_clk); while (!box_in.ready);
        expected_bounds_q.push_back(predict_bounds(b));
    endtask

    // sender pause until every result is back, with nothing offered meanwhile
    task automatic wait_drained();
        box_in.valid <= 1'b0;
        do @(posedge i_clk); while (expected_bounds_q.size() != 0);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100) $display("mismatch: %s", msg);
    endtask

    // result ready: random stalls, plus a long hold when asked
    initial begin
        int stall;
        box_out.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = rx_hold_cycles + (rx_idle ? $urandom_range(0, 7) : 0);
            rx_hold_cycles = 0;
            if (stall > 0) begin
                box_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            box_out.ready <= 1'b1;
            do @(posedge i_clk); while (!box_out.valid);
        end
    end

    // compare each result transaction with the oldest expectation
    initial begin
        t_bounds got;
        t_bounds want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && box_out.valid && box_out.ready) begin
                got.f = '{box_out.aabb_min_x, box_out.aabb_min_y, box_out.aabb_min_z,
                          box_out.aabb_max_x, box_out.aabb_max_y, box_out.aabb_max_z,
                          box_out.moved_min_x, box_out.moved_min_y,
                          box_out.moved_min_z, box_out.moved_max_x,
                          box_out.moved_max_y, box_out.moved_max_z};
                if (expected_bounds_q.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = expected_bounds_q.pop_front();
                    for (int i = 0; i < 12; i++) begin
                        if (got.f[i] !== want.f[i])
                            report_mismatch($sformatf("%s_%s got %0d expected %0d",
                                group_names[i / 3], axis_names[i % 3],
                                got.f[i], want.f[i]));
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // identity, mirror, axis swap and pure translation
    task automatic test_plain_transforms();
        taab_pkg::t_row id_x;
        taab_pkg::t_row id_y;
        taab_pkg::t_row id_z;
        id_x = pack_row(ONE, 0, 0, 0);
        id_y = pack_row(0, ONE, 0, 0);
        id_z = pack_row(0, 0, ONE, 0);
        send_box(make_box(-256, -512, -768, 256, 512, 768, id_x, id_y, id_z));
        send_box(make_box(P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX, id_x, id_y, id_z));
        send_box(make_box(100, 200, 300, 400, 500, 600,
                          pack_row(ONE, 0, 0, 16'sh0100),
                          pack_row(0, ONE, 0, 16'shFF00),
                          pack_row(0, 0, ONE, 16'sh1234)));
        send_box(make_box(-1000, 20, -5, 3000, 40, 7,
                          pack_row(NEG_ONE, 0, 0, 0),
                          pack_row(0, NEG_ONE, 0, 0),
                          pack_row(0, 0, NEG_ONE, 0)));
        send_box(make_box(-300, 10, 50, 700, 90, 60,
                          pack_row(0, ONE, 0, 0),
                          pack_row(NEG_ONE, 0, 0, 0),
                          pack_row(0, 0, ONE, ONE)));
        // translation only: extreme offsets
        send_box(make_box(P_MIN, 0, P_MAX, P_MAX, 0, P_MIN,
                          pack_row(0, 0, 0, C_MAX),
                          pack_row(0, 0, 0, C_MIN),
                          pack_row(0, 0, 0, 0)));
        send_box(make_box(0, 0, 0, 0, 0, 0,
                          {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}));
    endtask

    // exact halves round upwards, just below a half rounds down
    task automatic test_rounding_halves();
        send_box(make_box(2048, 2047, -2048, 6144, -2049, -6144,
                          pack_row(1, 0, 0, 0),
                          pack_row(0, 0, 0, 8),
                          pack_row(0, 0, 0, -8)));
        send_box(make_box(2047, 0, 0, -2049, 0, 0,
                          pack_row(1, 0, 0, 0),
                          pack_row(0, 1, 0, 8),
                          pack_row(0, 0, 1, -8)));
        send_box(make_box(-2048, 1, -1, 2048, -1, 1,
                          pack_row(-1, 0, 0, 0),
                          pack_row(0, 2048, 0, 0),
                          pack_row(0, 0, -2048, 0)));
    endtask

    // products far outside Q8.8 clamp to the limits
    task automatic test_saturation();
        send_box(make_box(P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX,
                          pack_row(C_MAX, C_MAX, C_MAX, C_MAX),
                          pack_row(C_MIN, C_MIN, C_MIN, C_MIN),
                          pack_row(C_MAX, C_MIN, C_MAX, C_MIN)));
        send_box(make_box(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX,
                          pack_row(C_MAX, C_MAX, C_MAX, C_MAX),
                          pack_row(C_MIN, C_MIN, C_MIN, C_MIN),
                          pack_row(ONE, 0, 0, 0)));
        send_box(make_box(P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN,
                          pack_row(C_MIN, C_MIN, C_MIN, C_MIN),
                          pack_row(C_MAX, C_MAX, C_MAX, C_MAX),
                          pack_row(NEG_ONE, 0, 0, 0)));
        send_box(make_box(16000, -16000, 0, 20000, -12000, 100,
                          pack_row(16'sh3000, 0, 0, 0),
                          pack_row(0, 16'sh3000, 0, 0),
                          pack_row(0, 0, C_MAX, 0)));
    endtask

    // min above max on some or all axes: moved corners stay unsorted
    task automatic test_inverted_boxes();
        send_box(make_box(500, 600, 700, -500, -600, -700,
                          pack_row(ONE, 0, 0, 0),
                          pack_row(0, ONE, 0, 0),
                          pack_row(0, 0, ONE, 0)));
        send_box(make_box(P_MAX, -10, P_MAX, P_MIN, 10, P_MIN,
                          pack_row(16'sh0B50, 16'shF4B0, 0, 16'sh0200),
                          pack_row(16'sh0B50, 16'sh0B50, 0, 16'shFE00),
                          pack_row(0, 0, NEG_ONE, 0)));
        send_box(make_box(1000, 0, 0, 0, 0, 0,
                          pack_row(ONE, ONE, ONE, 0),
                          pack_row(NEG_ONE, ONE, 0, 0),
                          pack_row(0, 0, 0, ONE)));
    endtask

    // receiver holds off long while boxes keep coming, so the input stalls
    task automatic test_output_stall();
        wait_drained();
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        rx_hold_cycles = 64;
        repeat (24) send_box(rand_box());
        wait_drained();
    endtask

    // long random stream in segments with different idling on each side
    task automatic test_random_boxes();
        for (int seg = 0; seg < 10; seg++) begin
            tx_idle = seg[0];
            rx_idle = seg[1];
            if (seg == 5) wait_drained();
            repeat (160) send_box(rand_box());
        end
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------
    initial begin
        box_in.valid        <= 1'b0;
        box_in.local_min_x  <= '0;
        box_in.local_min_y  <= '0;
        box_in.local_min_z  <= '0;
        box_in.local_max_x  <= '0;
        box_in.local_max_y  <= '0;
        box_in.local_max_z  <= '0;
        box_in.matrix_row_x <= '0;
        box_in.matrix_row_y <= '0;
        box_in.matrix_row_z <= '0;
        i_rst_n             <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_transforms();
        test_rounding_halves();
        test_saturation();
        test_inverted_boxes();
        test_output_stall();
        test_random_boxes();

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS transformed_aabb_bounds");
        end else begin
            $display("FAIL transformed_aabb_bounds");
        end
        $finish;
    end

endmodule

`default_nettype wire
